>>> hdl/svt_pkg.sv
`timescale 1ns / 1ps
// Package for the sorted value table: item payload types, operation and
// status codes, sequencer states and the cell control bundle. No dependencies.
package svt_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_FIELD_W = 5;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic                      operation;
        logic signed [VALUE_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                status;
        logic [COUNT_FIELD_W-1:0]  entry_count;
        logic signed [VALUE_W-1:0] smallest_value;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY,
        S_OUT
    } t_state;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic compare;
        logic ins;
        logic del;
    } t_cell_ctl;

endpackage

>>> hdl/sorted_value_table.sv
`timescale 1ns / 1ps
// Top level of the sorted value table: sequencer, count and the chain of
// svt_cell instances. Uses svt_pkg.
//
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_in_item) carries an operation,
//   insert or delete, and a signed 32-bit value. Output channel (o_out_valid,
//   i_out_stall, o_out_item) returns one item per input item: status, the
//   count after the operation and the smallest stored value (zero if empty).
//   Every cell compares its value with the item in the compare step, and in the
//   next cycle all cells shift toward or away from the insert or delete
//   point at once. The result is presented in the following cycle.
//   One item is in work at a time: a new item is taken only in the idle
//   state, after the compare, shift and result steps of the sequencer are
//   through for the last one and its result has been taken.
//   While the receiver stalls, the result holds and no new item is taken.
//   Reset empties the table at once; no clearing pass is needed. An insert
//   into a full table is dropped with status full; a delete of an absent
//   value leaves the table as it was with status not found.
module sorted_value_table import svt_pkg::*; #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    t_state r_state;
    t_state n_state;

    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [1:0]                r_status;
    logic [1:0]                n_status;
    logic                      r_op;
    logic signed [VALUE_W-1:0] r_item;

    t_cell_ctl ctl;
    logic      accept;
    logic      found;
    logic      full;
    logic [31:0] count_ext;

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]       sel_ins;
    logic [CAPACITY-1:0]       sel_del;
    logic [CAPACITY-1:0]       hit;
    logic [CAPACITY-1:0]       occ;

    assign accept = i_in_valid && !o_in_stall;
    assign found  = |hit;
    assign full   = (r_count >= CW'(CAPACITY));

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic                      left_sel;
            logic signed [VALUE_W-1:0] left_value;
            logic signed [VALUE_W-1:0] right_value;

            assign occ[g] = (r_count > CW'(g));

            if (g == 0) begin : g_first
                assign left_sel   = 1'b0;
                assign left_value = '0;
            end else begin : g_inner
                assign left_sel   = sel_ins[g-1];
                assign left_value = cell_value[g-1];
            end

            if (g == CAPACITY - 1) begin : g_last
                assign right_value = '0;
            end else begin : g_mid
                assign right_value = cell_value[g+1];
            end

            svt_cell u_cell (
                .i_clk         (i_clk),
                .i_ctl         (ctl),
                .i_item        (r_item),
                .i_occ         (occ[g]),
                .i_left_sel    (left_sel),
                .i_left_value  (left_value),
                .i_right_value (right_value),
                .o_value       (cell_value[g]),
                .o_sel_ins     (sel_ins[g]),
                .o_sel_del     (sel_del[g]),
                .o_hit         (hit[g])
            );
        end
    endgenerate

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_status     = r_status;
        ctl          = '0;
        o_in_stall   = 1'b1;
        o_out_valid  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                ctl.compare = 1'b1;
                n_state     = S_APPLY;
            end
            S_APPLY: begin
                if (r_op == OP_INSERT) begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else begin
                        ctl.ins  = 1'b1;
                        n_count  = r_count + CW'(1);
                        n_status = ST_DONE;
                    end
                end else begin
                    if (found) begin
                        ctl.del  = 1'b1;
                        n_count  = r_count - CW'(1);
                        n_status = ST_DONE;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        if (accept) begin
            r_op   <= i_in_item.operation;
            r_item <= i_in_item.item_value;
        end
    end

    assign count_ext                 = 32'(r_count);
    assign o_out_item.status         = r_status;
    assign o_out_item.entry_count    = count_ext[COUNT_FIELD_W-1:0];
    assign o_out_item.smallest_value = (r_count != '0) ? cell_value[0] : '0;

endmodule

>>> hdl/svt_cell.sv
`timescale 1ns / 1ps
// One cell of the sorted chain: holds one value and its compare flags, and takes
// the item or a left or right neighbor's value on insert or delete. Uses svt_pkg.
module svt_cell import svt_pkg::*; (
    input  logic                      i_clk,
    input  t_cell_ctl                 i_ctl,
    input  logic signed [VALUE_W-1:0] i_item,
    input  logic                      i_occ,
    input  logic                      i_left_sel,
    input  logic signed [VALUE_W-1:0] i_left_value,
    input  logic signed [VALUE_W-1:0] i_right_value,
    output logic signed [VALUE_W-1:0] o_value,
    output logic                      o_sel_ins,
    output logic                      o_sel_del,
    output logic                      o_hit
);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      r_ge;
    logic                      n_ge;
    logic                      r_eq;
    logic                      n_eq;

    // An empty cell counts as greater than anything on insert, so the
    // new value lands in the first free cell when it is the largest.
    assign o_sel_ins = !i_occ || r_ge;
    assign o_sel_del = i_occ && r_ge;
    assign o_hit     = i_occ && r_eq;
    assign o_value   = r_value;

    always_comb begin
        n_value = r_value;
        n_ge    = r_ge;
        n_eq    = r_eq;
        if (i_ctl.compare) begin
            n_ge = (r_value >= i_item);
            n_eq = (r_value == i_item);
        end
        if (i_ctl.ins && o_sel_ins) begin
            n_value = i_left_sel ? i_left_value : i_item;
        end else if (i_ctl.del && o_sel_del) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_ge    <= n_ge;
        r_eq    <= n_eq;
    end

endmodule

>>> tb/sorted_value_table_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sorted_value_table: insert and delete items
// against a bounded sorted table model, with random idling on both sides.
// Depends on svt_pkg and the sorted_value_table RTL.
module sorted_value_table_tb;
    import svt_pkg::*;

    localparam int unsigned CAPACITY = 16;
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES = 160;
    localparam int IDLE_LIMIT = 1000;
    localparam int TAIL_CYCLES = 8;
    localparam int RANDOM_ITEMS = 480;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  in_item = '0;
    logic      o_out_valid;
    logic      out_stall = 1'b0;
    t_out_item o_out_item;

    // Model of the table, updated as each input item is accepted.
    logic signed [VALUE_W-1:0] model_vals [CAPACITY];
    int unsigned               model_count = 0;
    t_out_item                 pending_results [$];

    bit stall_on = 1'b0;
    bit idle_on = 1'b0;
    bit hold_pending = 1'b0;
    int fail_count = 0;
    int idle_cycles = 0;
    int n_insert = 0;
    int n_delete = 0;
    int n_full = 0;
    int n_not_found = 0;
    int unsigned peak_count = 0;

    sorted_value_table #(.CAPACITY(CAPACITY)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_item (o_out_item)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Applies one item to the model table and returns the result it should give.
    function automatic t_out_item apply_table_op(t_in_item it);
        t_out_item                 res;
        logic signed [VALUE_W-1:0] v;
        int unsigned               pos;
        v = it.item_value;
        res.status = ST_DONE;
        pos = 0;
        if (it.operation == OP_INSERT) begin
            if (model_count >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                // Equal values already stored stay behind the new one.
                while (pos < model_count && model_vals[pos] < v) pos++;
                for (int unsigned i = model_count; i > pos; i--)
                    model_vals[i] = model_vals[i-1];
                model_vals[pos] = v;
                model_count++;
            end
        end else begin
            while (pos < model_count && model_vals[pos] != v) pos++;
            if (pos >= model_count) begin
                res.status = ST_NOT_FOUND;
            end else begin
                for (int unsigned i = pos; i + 1 < model_count; i++)
                    model_vals[i] = model_vals[i+1];
                model_count--;
            end
        end
        res.entry_count = COUNT_FIELD_W'(model_count);
        res.smallest_value = (model_count > 0) ? model_vals[0] : '0;
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Full-range values, plus small and extreme values that collide often.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return $urandom;
        if (r < 7) begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return -1;
                default: return 0;
            endcase
        end
        return $signed($urandom_range(0, 15)) - 8;
    endfunction

    // Input acceptance, result checking and the no-progress watchdog.
    always @(posedge i_clk) begin
        t_out_item exp_res;
        bit        moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (in_valid && !o_in_stall) begin
                moved = 1'b1;
                if (in_item.operation == OP_INSERT) n_insert++;
                else n_delete++;
                pending_results.push_back(apply_table_op(in_item));
                if (model_count > peak_count) peak_count = model_count;
            end
            if (o_out_valid && !out_stall) begin
                moved = 1'b1;
                if (pending_results.size() == 0) begin
                    $error("result item with no input item waiting for it");
                    fail_count++;
                end else begin
                    exp_res = pending_results.pop_front();
                    if (exp_res.status == ST_FULL) n_full++;
                    if (exp_res.status == ST_NOT_FOUND) n_not_found++;
                    if (o_out_item.status !== exp_res.status) begin
                        $error("status: expected %0d, got %0d",
                               exp_res.status, o_out_item.status);
                        fail_count++;
                    end
                    if (o_out_item.entry_count !== exp_res.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               exp_res.entry_count, o_out_item.entry_count);
                        fail_count++;
                    end
                    if (o_out_item.smallest_value !== exp_res.smallest_value) begin
                        $error("smallest_value: expected %0d, got %0d",
                               exp_res.smallest_value, o_out_item.smallest_value);
                        fail_count++;
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no item moved for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Receiver side: random stall bursts, or one long hold when asked for.
    always begin
        @(posedge i_clk);
        if (hold_pending) begin
            out_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            out_stall <= 1'b0;
            hold_pending = 1'b0;
        end else if (stall_on && $urandom_range(0, 3) == 0) begin
            out_stall <= 1'b1;
            repeat (1 + gap_len()) @(posedge i_clk);
            out_stall <= 1'b0;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Offers one item and returns at the edge where it is accepted.
    task automatic send_item(input logic op, input logic signed [VALUE_W-1:0] v);
        t_in_item it;
        int       gap;
        it.operation = op;
        it.item_value = v;
        gap = idle_on ? gap_len() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Stops offering the last item so it is not taken twice, then waits
    // until every accepted item has its result.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Deletes every stored value in random order, then one that is gone.
    task automatic empty_table();
        logic signed [VALUE_W-1:0] vals [$];
        logic signed [VALUE_W-1:0] v;
        int                        idx;
        wait_drained();
        for (int unsigned i = 0; i < model_count; i++) vals.push_back(model_vals[i]);
        v = pick_value();
        while (vals.size() != 0) begin
            idx = $urandom_range(0, vals.size() - 1);
            v = vals[idx];
            vals.delete(idx);
            send_item(OP_DELETE, v);
        end
        send_item(OP_DELETE, v);
    endtask

    task automatic test_directed_edges();
        send_item(OP_DELETE, 0);
        send_item(OP_INSERT, 0);
        send_item(OP_INSERT, VAL_MAX);
        send_item(OP_INSERT, VAL_MIN);
        send_item(OP_INSERT, -1);
        send_item(OP_INSERT, 1);
        send_item(OP_INSERT, VAL_MIN);
        send_item(OP_DELETE, VAL_MIN);
        send_item(OP_DELETE, VAL_MIN);
        send_item(OP_DELETE, 12345);
        send_item(OP_DELETE, VAL_MAX);
        send_item(OP_INSERT, 32'sh5555_5555);
        send_item(OP_INSERT, 32'shaaaa_aaaa);
        send_item(OP_DELETE, 0);
        send_item(OP_DELETE, -1);
        send_item(OP_DELETE, 1);
        send_item(OP_DELETE, 32'sh5555_5555);
        send_item(OP_DELETE, 32'shaaaa_aaaa);
        send_item(OP_DELETE, 32'shaaaa_aaaa);
    endtask

    // Fills the table past capacity so that inserts are dropped, then empties it.
    task automatic test_fill_overflow();
        repeat (2) begin
            empty_table();
            repeat (CAPACITY + 3) send_item(OP_INSERT, pick_value());
            empty_table();
        end
    endtask

    // The receiver holds off while items keep coming, so the input stalls too.
    task automatic test_output_hold();
        hold_pending = 1'b1;
        repeat (12) send_item(1'($urandom_range(0, 1)), pick_value());
        while (hold_pending) @(posedge i_clk);
        wait_drained();
    endtask

    // Alternating grow and shrink phases keep the count sweeping its range.
    task automatic test_random_mix();
        logic signed [VALUE_W-1:0] v;
        logic                      op;
        int                        insert_pct;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0) insert_pct = ((n / 40) % 2 == 0) ? 75 : 25;
            // One stretch runs with no idling on either side.
            idle_on = !(n >= 200 && n < 280);
            stall_on = idle_on;
            op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
            v = pick_value();
            if (op == OP_DELETE && model_count > 0 && $urandom_range(0, 9) < 7)
                v = model_vals[$urandom_range(0, model_count - 1)];
            send_item(op, v);
        end
        idle_on = 1'b1;
        stall_on = 1'b1;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_on = 1'b1;
        stall_on = 1'b1;

        test_directed_edges();
        test_fill_overflow();
        test_output_hold();
        test_random_mix();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d inserts and %0d deletes, peak count %0d of %0d,",
                 n_insert, n_delete, peak_count, CAPACITY);
        $display("with %0d dropped inserts on a full table and %0d deletes not found.",
                 n_full, n_not_found);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
